### sv/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the directory table RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/tldt_pkg.sv
// ============================================================================
// Directory table package
// Request and status codes and the command and status bundles that join the
// controller and the datapath.
// ============================================================================
package tldt_pkg;

    typedef enum logic [1:0] {
        REQ_MKDIR  = 2'd0,
        REQ_MKFILE = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_SEARCH = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_DIR  = 2'd1,
        ST_NO_FILE = 2'd2,
        ST_NO_ROOM = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        DIX_ZERO,
        DIX_COUNT,
        DIX_FOUND
    } dix_sel_t;

    typedef enum logic [1:0] {
        SLOT_ZERO,
        SLOT_COUNT,
        SLOT_HIT,
        SLOT_HELD
    } slot_sel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DSCAN,
        S_DECIDE,
        S_FSCAN,
        S_DMOVE
    } state_t;

    typedef struct packed {
        logic      load;
        logic      mkdir;
        logic      scan;
        logic      dsel;
        logic      mkfile;
        logic      del_rd;
        logic      del_wr;
        logic      result;
        status_t   res_status;
        dix_sel_t  dix_sel;
        slot_sel_t slot_sel;
    } tldt_cmd_t;

    typedef struct packed {
        req_type_t req;
        logic      dir_full;
        logic      file_full;
        logic      hit;
        logic      miss;
    } tldt_sts_t;

endpackage

### sv/tldt_ctrl.sv
// ============================================================================
// Directory table controller
// Sequences each request through the directory scan, file scan and update steps that it needs.
// ============================================================================
`include "assert_macros.svh"

module tldt_ctrl
    import tldt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  tldt_sts_t sts,
    output tldt_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.res_status = ST_DONE;
        cmd.dix_sel    = DIX_ZERO;
        cmd.slot_sel   = SLOT_ZERO;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.req == REQ_MKDIR)
                begin
                    cmd.result = 1'b1;
                    state_next = S_IDLE;
                    if (sts.dir_full)
                    begin
                        cmd.res_status = ST_NO_ROOM;
                    end
                    else
                    begin
                        cmd.mkdir   = 1'b1;
                        cmd.dix_sel = DIX_COUNT;
                    end
                end
                else
                begin
                    state_next = S_DSCAN;
                end
            end
            S_DSCAN:
            begin
                priority if (sts.hit)
                begin
                    cmd.dsel   = 1'b1;
                    state_next = S_DECIDE;
                end
                else if (sts.miss)
                begin
                    cmd.result     = 1'b1;
                    cmd.res_status = ST_NO_DIR;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            S_DECIDE:
            begin
                cmd.dix_sel = DIX_FOUND;
                if (sts.req == REQ_MKFILE)
                begin
                    cmd.result = 1'b1;
                    state_next = S_IDLE;
                    if (sts.file_full)
                    begin
                        cmd.res_status = ST_NO_ROOM;
                    end
                    else
                    begin
                        cmd.mkfile   = 1'b1;
                        cmd.slot_sel = SLOT_COUNT;
                    end
                end
                else
                begin
                    state_next = S_FSCAN;
                end
            end
            S_FSCAN:
            begin
                cmd.dix_sel = DIX_FOUND;
                priority if (sts.hit)
                begin
                    if (sts.req == REQ_SEARCH)
                    begin
                        cmd.result   = 1'b1;
                        cmd.slot_sel = SLOT_HIT;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cmd.del_rd = 1'b1;
                        state_next = S_DMOVE;
                    end
                end
                else if (sts.miss)
                begin
                    cmd.result     = 1'b1;
                    cmd.res_status = ST_NO_FILE;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            S_DMOVE:
            begin
                cmd.del_wr   = 1'b1;
                cmd.result   = 1'b1;
                cmd.dix_sel  = DIX_FOUND;
                cmd.slot_sel = SLOT_HELD;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted request did not raise busy")
    `ASSERT_ALWAYS(a_one_write, clk, rst_n, $onehot0({cmd.mkdir, cmd.mkfile, cmd.del_wr}), "more than one table write in a cycle")
    `ASSERT_IMPLIES(a_move_order, clk, rst_n, cmd.del_wr, $past(cmd.del_rd), "file move written without reading the last file")

endmodule

### sv/tldt_datapath.sv
// ============================================================================
// Directory table datapath
// Name memories, counts, the one-compare-per-cycle scan and the result
// registers.
// ============================================================================
`include "assert_macros.svh"

module tldt_datapath
    import tldt_pkg::*;
#(
    parameter int MAX_DIRS      = 16,
    parameter int FILES_PER_DIR = 16,
    parameter int NAME_BYTES    = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  req_type,
    input  logic [63:0] dir_name,
    input  logic [63:0] file_name,
    input  tldt_cmd_t   cmd,
    output tldt_sts_t   sts,
    output logic        done,
    output logic [1:0]  status,
    output logic [3:0]  dir_index,
    output logic [3:0]  file_slot
);

    localparam int MAXN   = (MAX_DIRS > FILES_PER_DIR) ? MAX_DIRS : FILES_PER_DIR;
    localparam int FDEPTH = MAX_DIRS * FILES_PER_DIR;
    localparam int DIW    = (MAX_DIRS > 1) ? $clog2(MAX_DIRS) : 1;
    localparam int FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
    localparam int DCW    = $clog2(MAX_DIRS + 1);
    localparam int FCW    = $clog2(FILES_PER_DIR + 1);
    localparam int SW     = $clog2(MAXN + 1);

    function automatic logic [63:0] canon(input logic [63:0] raw);
        logic [63:0] o;
        logic        live;
        o    = '0;
        live = 1'b1;
        for (int b = 0; b < 8; b++)
        begin
            if ((b >= NAME_BYTES) || (raw[8*b +: 8] == 8'h00))
            begin
                live = 1'b0;
            end
            if (live)
            begin
                o[8*b +: 8] = raw[8*b +: 8];
            end
        end
        return o;
    endfunction

    logic [63:0]    dir_mem  [MAX_DIRS];
    logic [FCW-1:0] cnt_mem  [MAX_DIRS];
    logic [63:0]    file_mem [FDEPTH];

    req_type_t      req_reg;
    logic [63:0]    dname_reg;
    logic [63:0]    fname_reg;
    logic [DCW-1:0] dir_count_reg;
    logic [SW-1:0]  scan_idx_reg;
    logic           pend_reg;
    logic [SW-1:0]  pend_idx_reg;
    logic           scan_file_reg;
    logic [63:0]    dir_rd_reg;
    logic [63:0]    file_rd_reg;
    logic [DIW-1:0] dix_reg;
    logic [FAW-1:0] fbase_reg;
    logic [FCW-1:0] fcnt_reg;
    logic [SW-1:0]  slot_reg;
    logic           done_reg;
    status_t        status_reg;
    logic [3:0]     dix_out_reg;
    logic [3:0]     slot_out_reg;

    logic [SW-1:0]  limit;
    logic           issue;
    logic           dir_rd_en;
    logic           file_rd_en;
    logic [FAW-1:0] file_raddr;
    logic           file_wr_en;
    logic [FAW-1:0] file_waddr;
    logic [63:0]    file_wdata;
    logic           cnt_wr_en;
    logic [DIW-1:0] cnt_waddr;
    logic [FCW-1:0] cnt_wdata;
    logic [3:0]     dix_next;
    logic [3:0]     slot_next;

    assign limit = scan_file_reg ? SW'(fcnt_reg) : SW'(dir_count_reg);
    assign issue = cmd.scan && (scan_idx_reg < limit);

    assign dir_rd_en  = issue && !scan_file_reg;
    assign file_rd_en = (issue && scan_file_reg) || cmd.del_rd;
    assign file_raddr = cmd.del_rd ? FAW'(fbase_reg + FAW'(fcnt_reg) - FAW'(1))
                                   : FAW'(fbase_reg + FAW'(scan_idx_reg));

    assign file_wr_en = cmd.mkfile || cmd.del_wr;
    assign file_waddr = cmd.del_wr ? FAW'(fbase_reg + FAW'(slot_reg))
                                   : FAW'(fbase_reg + FAW'(fcnt_reg));
    assign file_wdata = cmd.del_wr ? file_rd_reg : fname_reg;

    always_comb
    begin
        cnt_wr_en = cmd.mkdir || cmd.mkfile || cmd.del_wr;
        cnt_waddr = dix_reg;
        cnt_wdata = fcnt_reg;
        priority if (cmd.mkdir)
        begin
            cnt_waddr = dir_count_reg[DIW-1:0];
            cnt_wdata = '0;
        end
        else if (cmd.mkfile)
        begin
            cnt_wdata = FCW'(fcnt_reg + FCW'(1));
        end
        else if (cmd.del_wr)
        begin
            cnt_wdata = FCW'(fcnt_reg - FCW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mkdir)
        begin
            dir_mem[dir_count_reg[DIW-1:0]] <= dname_reg;
        end
        if (dir_rd_en)
        begin
            dir_rd_reg <= dir_mem[scan_idx_reg[DIW-1:0]];
        end
        if (cnt_wr_en)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cmd.dsel)
        begin
            fcnt_reg <= cnt_mem[pend_idx_reg[DIW-1:0]];
        end
        if (file_wr_en)
        begin
            file_mem[file_waddr] <= file_wdata;
        end
        if (file_rd_en)
        begin
            file_rd_reg <= file_mem[file_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req_type_t'(req_type);
            dname_reg <= canon(dir_name);
            fname_reg <= canon(file_name);
        end
        if (cmd.scan)
        begin
            pend_idx_reg <= scan_idx_reg;
        end
        if (cmd.dsel)
        begin
            dix_reg   <= pend_idx_reg[DIW-1:0];
            fbase_reg <= FAW'(pend_idx_reg * FILES_PER_DIR);
        end
        if (cmd.del_rd)
        begin
            slot_reg <= pend_idx_reg;
        end
        if (cmd.result)
        begin
            status_reg   <= cmd.res_status;
            dix_out_reg  <= dix_next;
            slot_out_reg <= slot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_count_reg <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            scan_file_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.result;
            if (cmd.mkdir)
            begin
                dir_count_reg <= DCW'(dir_count_reg + DCW'(1));
            end
            if (cmd.load || cmd.dsel)
            begin
                scan_idx_reg  <= '0;
                pend_reg      <= 1'b0;
                scan_file_reg <= cmd.dsel;
            end
            else if (cmd.scan)
            begin
                pend_reg <= issue;
                if (issue)
                begin
                    scan_idx_reg <= SW'(scan_idx_reg + SW'(1));
                end
            end
        end
    end

    always_comb
    begin
        unique case (cmd.dix_sel)
            DIX_ZERO:  dix_next = '0;
            DIX_COUNT: dix_next = 4'(dir_count_reg);
            DIX_FOUND: dix_next = 4'(dix_reg);
            default:   dix_next = '0;
        endcase
        unique case (cmd.slot_sel)
            SLOT_ZERO:  slot_next = '0;
            SLOT_COUNT: slot_next = 4'(fcnt_reg);
            SLOT_HIT:   slot_next = 4'(pend_idx_reg);
            SLOT_HELD:  slot_next = 4'(slot_reg);
            default:    slot_next = '0;
        endcase
    end

    assign sts.req       = req_reg;
    assign sts.dir_full  = (dir_count_reg >= DCW'(MAX_DIRS));
    assign sts.file_full = (fcnt_reg >= FCW'(FILES_PER_DIR));
    assign sts.hit       = pend_reg && (scan_file_reg ? (file_rd_reg == fname_reg)
                                                      : (dir_rd_reg == dname_reg));
    assign sts.miss      = !pend_reg && (scan_idx_reg >= limit);

    assign done      = done_reg;
    assign status    = status_reg;
    assign dir_index = dix_out_reg;
    assign file_slot = slot_out_reg;

    `ASSERT_ALWAYS(a_dir_bound, clk, rst_n, dir_count_reg <= DCW'(MAX_DIRS), "directory count beyond capacity")
    `ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg, "result strobe held for two cycles")

endmodule

### sv/two_level_directory_table_top.sv
// ============================================================================
// Two-level directory table
// Directory and file name table with create, delete and search requests.
// ============================================================================
// A request (req_type, dir_name, file_name) is taken at a rising edge where
// start is high and busy is low. Names are up to NAME_BYTES ASCII bytes,
// first character in the low byte; bytes after the first zero are ignored.
// Every request yields one result transfer: done pulses for one cycle with
// status, dir_index and file_slot. The receiver cannot stall; the result is
// simply presented for that cycle.
// Create directory is decided without a scan. The other requests first scan
// the directories, and all but create file then scan the files. The directory
// scan and the file scan each compare one stored name per cycle against a
// single-port name memory, and delete adds one read and one write of the file
// memory to move the last file.
// busy stays high for the whole request, so one request is in work at a time;
// a new request may be accepted in the cycle done is shown.
// Reset empties the directory list at once; the name memories need no clear.
// ============================================================================
module two_level_directory_table_top
    import tldt_pkg::*;
#(
    parameter int MAX_DIRS      = 16,
    parameter int FILES_PER_DIR = 16,
    parameter int NAME_BYTES    = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [63:0] dir_name,
    input  logic [63:0] file_name,
    output logic        done,
    output logic [1:0]  status,
    output logic [3:0]  dir_index,
    output logic [3:0]  file_slot
);

    tldt_cmd_t cmd;
    tldt_sts_t sts;

    tldt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    tldt_datapath #(
        .MAX_DIRS      (MAX_DIRS),
        .FILES_PER_DIR (FILES_PER_DIR),
        .NAME_BYTES    (NAME_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_type  (req_type),
        .dir_name  (dir_name),
        .file_name (file_name),
        .cmd       (cmd),
        .sts       (sts),
        .done      (done),
        .status    (status),
        .dir_index (dir_index),
        .file_slot (file_slot)
    );

endmodule

### tb/two_level_directory_table_top_tb.sv
// ============================================================================
// Two-level directory table testbench
// Drives create directory, create file, delete and search requests through the
// start/busy handshake. A directed table runs first: empty-table lookups, name
// extremes, junk after the terminating zero byte, duplicate directory names and
// the delete move. Random traffic follows. It grows and then drains the
// directories in turns, so full directories and the full directory table are
// both reached. Every result transfer is checked in request order: typed rows
// against their listed values, all others against an in-bench model of the table.
// ============================================================================
module two_level_directory_table_top_tb;
    import tldt_pkg::*;

    localparam int NDIRS      = 16;
    localparam int NFILES     = 16;
    localparam int NBYTES     = 8;
    localparam int RAND_REQS  = 1700;
    localparam int DPOOL      = 8;
    localparam int FPOOL      = 24;

    typedef struct {
        status_t    st;
        logic [3:0] dix;
        logic [3:0] slot;
    } outcome_t;

    typedef struct {
        req_type_t   kind;
        logic [63:0] dname;
        logic [63:0] fname;
        bit          typed;
        outcome_t    res;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    req_type_t   req_type = REQ_MKDIR;
    logic [63:0] dir_name = '0;
    logic [63:0] file_name = '0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [3:0]  dir_index;
    logic [3:0]  file_slot;

    int          dir_total;
    logic [63:0] dir_tab [NDIRS];
    int          file_total [NDIRS];
    logic [63:0] file_tab [NDIRS][NFILES];

    dir_row_t    script[$];
    outcome_t    awaited[$];
    logic [63:0] dir_pool [DPOOL];
    logic [63:0] file_pool [FPOOL];
    int          errs = 0;
    int          idle_pct = 28;

    two_level_directory_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .dir_name  (dir_name),
        .file_name (file_name),
        .done      (done),
        .status    (status),
        .dir_index (dir_index),
        .file_slot (file_slot)
    );

    always #4 clk = ~clk;

    task automatic note_error(input string msg);
        errs++;
        if (errs <= 10)
        begin
            $display("mismatch: %s", msg);
        end
    endtask

    // A name ends at its first zero byte; anything after it does not count.
    function automatic logic [63:0] trim_name(input logic [63:0] raw);
        logic [63:0] keep;
        bit          ended;
        int          b;
        keep = '0;
        ended = 1'b0;
        for (b = 0; b < NBYTES; b++)
        begin
            if (raw[8*b +: 8] == 8'h00)
                ended = 1'b1;
            if (!ended)
                keep[8*b +: 8] = raw[8*b +: 8];
        end
        return keep;
    endfunction

    function automatic outcome_t apply_request(input req_type_t kind,
                                               input logic [63:0] dn_raw,
                                               input logic [63:0] fn_raw);
        outcome_t    res;
        logic [63:0] dn;
        logic [63:0] fn;
        int          hit_d;
        int          hit_f;
        int          i;
        res.st = ST_DONE;
        res.dix = '0;
        res.slot = '0;
        dn = trim_name(dn_raw);
        fn = trim_name(fn_raw);
        if (kind == REQ_MKDIR)
        begin
            if (dir_total >= NDIRS)
                res.st = ST_NO_ROOM;
            else
            begin
                res.dix = 4'(dir_total);
                dir_tab[dir_total] = dn;
                file_total[dir_total] = 0;
                dir_total++;
            end
        end
        else
        begin
            hit_d = -1;
            for (i = 0; i < dir_total; i++)
                if (hit_d < 0 && dir_tab[i] == dn)
                    hit_d = i;
            if (hit_d < 0)
                res.st = ST_NO_DIR;
            else
            begin
                res.dix = 4'(hit_d);
                if (kind == REQ_MKFILE)
                begin
                    if (file_total[hit_d] >= NFILES)
                        res.st = ST_NO_ROOM;
                    else
                    begin
                        res.slot = 4'(file_total[hit_d]);
                        file_tab[hit_d][file_total[hit_d]] = fn;
                        file_total[hit_d]++;
                    end
                end
                else
                begin
                    hit_f = -1;
                    for (i = 0; i < file_total[hit_d]; i++)
                        if (hit_f < 0 && file_tab[hit_d][i] == fn)
                            hit_f = i;
                    if (hit_f < 0)
                        res.st = ST_NO_FILE;
                    else
                    begin
                        res.slot = 4'(hit_f);
                        if (kind == REQ_DELETE)
                        begin
                            file_total[hit_d]--;
                            file_tab[hit_d][hit_f] = file_tab[hit_d][file_total[hit_d]];
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic add_row(input req_type_t kind, input logic [63:0] dn,
                           input logic [63:0] fn, input bit typed,
                           input status_t st, input logic [3:0] dix,
                           input logic [3:0] slot);
        dir_row_t row;
        row.kind = kind;
        row.dname = dn;
        row.fname = fn;
        row.typed = typed;
        row.res.st = st;
        row.res.dix = dix;
        row.res.slot = slot;
        script.push_back(row);
    endtask

    function automatic logic [63:0] fresh_name();
        logic [63:0] n;
        int          len;
        int          b;
        n = '0;
        len = $urandom_range(0, NBYTES);
        for (b = 0; b < len; b++)
            n[8*b +: 8] = 8'($urandom_range(1, 255));
        return n;
    endfunction

    // Random bytes after the terminating zero must not change the name.
    function automatic logic [63:0] garble_tail(input logic [63:0] n);
        logic [63:0] junk;
        int          len;
        len = 0;
        while (len < NBYTES && n[8*len +: 8] != 8'h00)
            len++;
        if (len < NBYTES - 1 && $urandom_range(0, 1) == 1)
        begin
            junk = {$urandom, $urandom};
            junk = junk & ~((64'd1 << (8 * (len + 1))) - 64'd1);
            n = n | junk;
        end
        return n;
    endfunction

    function automatic logic [63:0] pick_dir();
        if ($urandom_range(0, 99) < 8)
            return {$urandom, $urandom};
        if ($urandom_range(0, 99) < 60)
            return garble_tail(dir_pool[$urandom_range(0, 3)]);
        return garble_tail(dir_pool[$urandom_range(0, DPOOL - 1)]);
    endfunction

    function automatic logic [63:0] pick_file();
        if ($urandom_range(0, 99) < 8)
            return {$urandom, $urandom};
        return garble_tail(file_pool[$urandom_range(0, FPOOL - 1)]);
    endfunction

    task automatic issue(input req_type_t kind, input logic [63:0] dn,
                         input logic [63:0] fn, input bit typed,
                         input outcome_t typed_res);
        outcome_t pred;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req_type <= kind;
        dir_name <= dn;
        file_name <= fn;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        pred = apply_request(kind, dn, fn);
        if (typed)
            awaited.push_back(typed_res);
        else
            awaited.push_back(pred);
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && $isunknown(done))
            note_error("done is unknown");
        else if (rst_n && done)
        begin
            if (awaited.size() == 0)
                note_error($sformatf("unexpected result status=%0d dir=%0d slot=%0d",
                                     status, dir_index, file_slot));
            else
            begin
                want = awaited.pop_front();
                if (status !== want.st || dir_index !== want.dix
                    || file_slot !== want.slot)
                    note_error($sformatf({"expected status=%0d dir=%0d slot=%0d, ",
                                          "got status=%0d dir=%0d slot=%0d"},
                                         want.st, want.dix, want.slot,
                                         status, dir_index, file_slot));
            end
        end
    end

    initial
    begin
        #8000000;
        $display("FAIL two_level_directory_table_top");
        $finish;
    end

    initial
    begin
        outcome_t  none;
        req_type_t kind;
        int        i;
        int        r;
        int        w_mk;
        int        w_del;
        int        waited;

        none.st = ST_DONE;
        none.dix = '0;
        none.slot = '0;
        dir_total = 0;
        for (i = 0; i < NDIRS; i++)
            file_total[i] = 0;
        for (i = 0; i < DPOOL; i++)
            dir_pool[i] = fresh_name();
        for (i = 0; i < FPOOL; i++)
            file_pool[i] = fresh_name();

        add_row(REQ_SEARCH, 64'h61, 64'h78, 1, ST_NO_DIR, 0, 0);
        add_row(REQ_MKFILE, 64'h61, 64'h78, 1, ST_NO_DIR, 0, 0);
        add_row(REQ_DELETE, 64'h0, 64'h0, 1, ST_NO_DIR, 0, 0);
        add_row(REQ_MKDIR, 64'h61, '1, 1, ST_DONE, 0, 0);
        add_row(REQ_MKDIR, '1, 64'h0, 1, ST_DONE, 1, 0);
        add_row(REQ_MKDIR, 64'h0, 64'h0, 1, ST_DONE, 2, 0);
        add_row(REQ_MKDIR, 64'hFFFF_0000_0000_0061, 64'h0, 1, ST_DONE, 3, 0);
        add_row(REQ_MKFILE, 64'h61, 64'h78, 1, ST_DONE, 0, 0);
        add_row(REQ_MKFILE, 64'hAAAA_AAAA_AAAA_0061, 64'h5555_5555_0000_00FF, 1,
                ST_DONE, 0, 1);
        add_row(REQ_MKFILE, 64'h61, 64'h7A79, 1, ST_DONE, 0, 2);
        add_row(REQ_SEARCH, 64'h61, 64'hFF, 1, ST_DONE, 0, 1);
        add_row(REQ_SEARCH, 64'h61, 64'h79, 1, ST_NO_FILE, 0, 0);
        add_row(REQ_DELETE, 64'h61, 64'h78, 1, ST_DONE, 0, 0);
        add_row(REQ_SEARCH, 64'h61, 64'h7A79, 1, ST_DONE, 0, 0);
        add_row(REQ_DELETE, 64'h61, 64'h78, 1, ST_NO_FILE, 0, 0);
        add_row(REQ_MKFILE, '1, '1, 1, ST_DONE, 1, 0);
        add_row(REQ_MKFILE, 64'h0, 64'h0, 1, ST_DONE, 2, 0);
        add_row(REQ_SEARCH, 64'h0, 64'hFF00, 1, ST_DONE, 2, 0);
        add_row(REQ_DELETE, 64'h0, 64'h0, 1, ST_DONE, 2, 0);
        add_row(REQ_SEARCH, 64'h0, 64'h0, 1, ST_NO_FILE, 2, 0);
        add_row(REQ_DELETE, 64'h61, 64'hFF, 1, ST_DONE, 0, 1);
        add_row(REQ_SEARCH, 64'h62, 64'h0, 1, ST_NO_DIR, 0, 0);
        add_row(REQ_MKFILE, '1, 64'h0123_4567_89AB_CDEF, 0, ST_DONE, 0, 0);
        add_row(REQ_SEARCH, '1, 64'h0123_4567_89AB_CDEF, 0, ST_DONE, 0, 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[n])
            issue(script[n].kind, script[n].dname, script[n].fname,
                  script[n].typed, script[n].res);

        // Growing and draining turns keep directories moving between empty and full.
        for (i = 0; i < RAND_REQS; i++)
        begin
            case (i * 3 / RAND_REQS)
                0:       idle_pct = 28;
                1:       idle_pct = 66;
                default: idle_pct = 0;
            endcase
            if (((i / 200) % 2) == 0)
            begin
                w_mk = 50;
                w_del = 15;
            end
            else
            begin
                w_mk = 15;
                w_del = 50;
            end
            r = $urandom_range(0, 99);
            if (r < 5)
                kind = REQ_MKDIR;
            else if (r < 5 + w_mk)
                kind = REQ_MKFILE;
            else if (r < 5 + w_mk + w_del)
                kind = REQ_DELETE;
            else
                kind = REQ_SEARCH;
            issue(kind, pick_dir(), pick_file(), 0, none);
        end
        start <= 1'b0;

        waited = 0;
        while (awaited.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (50) @(posedge clk);
        if (awaited.size() != 0)
            note_error($sformatf("%0d results never arrived", awaited.size()));

        if (errs == 0)
            $display("PASS two_level_directory_table_top");
        else
            $display("FAIL two_level_directory_table_top");
        $finish;
    end

endmodule
